// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: rtl/qwc_pkg.sv
// Package with payload types, constants and tables of the waypoint controller.
package qwc_pkg;
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] heading;
    logic signed [31:0] vel_u;
    logic signed [31:0] vel_v;
    logic [30:0] time_step;
  } qwc_in_t;

  typedef struct packed {
    logic signed [31:0] pitch_cmd;
    logic signed [31:0] roll_cmd;
    logic signed [31:0] yaw_rate_cmd;
    logic [16:0] throttle_cmd;
  } qwc_out_t;

  localparam logic [2:0] REG_GOAL_X = 3'd0;
  localparam logic [2:0] REG_GOAL_Y = 3'd1;
  localparam logic [2:0] REG_GOAL_Z = 3'd2;
  localparam logic [2:0] REG_GOAL_HEADING = 3'd3;
  localparam logic [2:0] REG_HOVER = 3'd4;
  localparam logic [2:0] REG_GAIN_P = 3'd5;
  localparam logic [2:0] REG_GAIN_I = 3'd6;
  localparam logic [2:0] REG_GAIN_D = 3'd7;

  localparam logic signed [63:0] Q_PI = 64'sd205887;
  localparam logic signed [63:0] Q_HALF_PI = 64'sd102944;
  localparam logic signed [63:0] Q_TWO_PI = 64'sd411775;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd39797;
  localparam int CORDIC_STAGES = 17;
  localparam int GUARD_BITS = 8;

  function automatic logic signed [63:0] atan_entry(input logic [4:0] i);
    logic signed [63:0] r;
    case (i)
      5'd0: r = 64'sd51472;
      5'd1: r = 64'sd30386;
      5'd2: r = 64'sd16055;
      5'd3: r = 64'sd8150;
      5'd4: r = 64'sd4091;
      5'd5: r = 64'sd2047;
      5'd6: r = 64'sd1024;
      5'd7: r = 64'sd512;
      5'd8: r = 64'sd256;
      5'd9: r = 64'sd128;
      5'd10: r = 64'sd64;
      5'd11: r = 64'sd32;
      5'd12: r = 64'sd16;
      5'd13: r = 64'sd8;
      5'd14: r = 64'sd4;
      5'd15: r = 64'sd2;
      5'd16: r = 64'sd1;
      default: r = 64'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    return clamp64(v, -64'sd2147483648, 64'sd2147483647);
  endfunction
endpackage

// File: rtl/quadrotor_waypoint_controller.sv
// Top level of the quadrotor waypoint controller.
// One input beat carries a measured vehicle state; one output beat carries
// the pitch, roll, yaw-rate and throttle commands for it.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. Configuration registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce it. A goal write clears the altitude loop.
// After the input beat is accepted, the result is formed by heading reduction
// by compare and subtract, a 17-step CORDIC rotation on one shared add/shift
// unit, waiting on a bit-serial divide of 64 quotient bits for the derivative,
// and multiplies through one shared 32x32 multiplier.
// The block is not ready from acceptance until its result beat has been
// taken; a stalled result holds in the output register.
// Reset clears the goals and gains, sets hover throttle to one half, clears
// the integrator and marks the next step as the first one.
`include "assert_macros.svh"
module quadrotor_waypoint_controller import qwc_pkg::*; #(
  parameter int POS_GAIN = 65536,
  parameter int VEL_GAIN = 65536,
  parameter int MAX_VELOCITY = 131072,
  parameter int MAX_TILT = 19661,
  parameter int YAW_GAIN = 65536,
  parameter int MAX_YAW_RATE = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  qwc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output qwc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_WRAP  = 12'b000000000010,
    S_CORD  = 12'b000000000100,
    S_SCALE = 12'b000000001000,
    S_PR    = 12'b000000010000,
    S_YAW   = 12'b000000100000,
    S_INT   = 12'b000001000000,
    S_DIV   = 12'b000010000000,
    S_PTERM = 12'b000100000000,
    S_ITERM = 12'b001000000000,
    S_DTERM = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;
  qwc_in_t item;
  logic signed [31:0] goal_x, goal_y, goal_z, goal_heading;
  logic [16:0] hover_throttle;
  logic signed [31:0] gain_p, gain_i, gain_d;
  logic signed [63:0] alt_integral;
  logic signed [31:0] last_err;
  logic first_step;

  logic signed [63:0] cx, cy, cz;
  logic [4:0] step;
  logic [1:0] sub;
  logic signed [31:0] err;
  logic signed [63:0] de, desth;
  logic signed [63:0] desu, desv, scl;
  logic [31:0] zm;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] mul_q;
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign mul_q = mul_p >>> 16;

  logic div_start, div_done;
  logic signed [63:0] div_q;
  qwc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(64'(64'(err) - 64'(last_err)) <<< 16),
    .divisor(item.time_step), .done(div_done), .quotient(div_q)
  );

  logic signed [63:0] zw, fx, fy, fz, xs, ys, at, bx, by, th;
  logic [31:0] wrap_sub;

  always_comb begin
    wrap_sub = 32'(Q_TWO_PI <<< (5'd12 - step));
    zw = {32'd0, zm};
    if (item.heading[31]) zw = -zw;
    if (zw < 0) zw = zw + Q_TWO_PI;
    if (zw > Q_PI) zw = zw - Q_TWO_PI;
    zw = -zw;
    fx = (64'(goal_x) - 64'(item.pos_x)) <<< GUARD_BITS;
    fy = (64'(goal_y) - 64'(item.pos_y)) <<< GUARD_BITS;
    fz = zw;
    if (zw > Q_HALF_PI) begin
      fx = -fx; fy = -fy; fz = zw - Q_PI;
    end else if (zw < -Q_HALF_PI) begin
      fx = -fx; fy = -fy; fz = zw + Q_PI;
    end
    xs = cx >>> step;
    ys = cy >>> step;
    at = atan_entry(step);
    bx = sat32(cx);
    by = sat32(cy);
    th = clamp64(desth, 64'sd0, 64'sd65536);
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (state)
      S_SCALE: begin
        mul_a = CORDIC_GAIN;
        case (sub)
          2'd0: mul_b = 32'(cx >>> 16);
          2'd1: mul_b = {16'd0, cx[15:0]};
          2'd2: mul_b = 32'(cy >>> 16);
          default: mul_b = {16'd0, cy[15:0]};
        endcase
      end
      S_PR: begin
        case (sub)
          2'd0: begin
            mul_a = 32'(POS_GAIN);
            mul_b = 32'(bx);
          end
          2'd1: begin
            mul_a = 32'(VEL_GAIN);
            mul_b = 32'(sat32(64'(item.vel_u) - desu));
          end
          2'd2: begin
            mul_a = 32'(POS_GAIN);
            mul_b = 32'(by);
          end
          default: begin
            mul_a = 32'(VEL_GAIN);
            mul_b = 32'(sat32(desv - 64'(item.vel_v)));
          end
        endcase
      end
      S_YAW: begin
        mul_a = 32'(YAW_GAIN);
        mul_b = 32'(sat32(64'(goal_heading) - 64'(item.heading)));
      end
      S_INT: begin
        mul_a = err;
        mul_b = {1'b0, item.time_step};
      end
      S_PTERM: begin
        mul_a = gain_p;
        mul_b = err;
      end
      S_ITERM: begin
        mul_a = gain_i;
        mul_b = 32'(sat32(alt_integral));
      end
      S_DTERM: begin
        mul_a = gain_d;
        mul_b = 32'(de);
      end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign div_start = (state == S_INT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      goal_x <= '0; goal_y <= '0; goal_z <= '0; goal_heading <= '0;
      hover_throttle <= 17'd32768;
      gain_p <= '0; gain_i <= '0; gain_d <= '0;
      alt_integral <= '0;
      last_err <= '0;
      first_step <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GOAL_X: goal_x <= cfg_data;
          REG_GOAL_Y: goal_y <= cfg_data;
          REG_GOAL_Z: goal_z <= cfg_data;
          REG_GOAL_HEADING: goal_heading <= cfg_data;
          REG_HOVER: hover_throttle <= cfg_data[16:0];
          REG_GAIN_P: gain_p <= cfg_data;
          REG_GAIN_I: gain_i <= cfg_data;
          REG_GAIN_D: gain_d <= cfg_data;
          default: ;
        endcase
        if (cfg_index inside {REG_GOAL_X, REG_GOAL_Y, REG_GOAL_Z, REG_GOAL_HEADING}) begin
          alt_integral <= '0;
          last_err <= '0;
          first_step <= 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            zm <= in_data.heading[31] ? 32'(-64'(in_data.heading))
                                      : 32'(in_data.heading);
            step <= 5'd0;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (step == 5'd13) begin
            cx <= fx;
            cy <= fy;
            cz <= fz;
            step <= 5'd0;
            state <= S_CORD;
          end else begin
            if (zm >= wrap_sub) zm <= zm - wrap_sub;
            step <= step + 5'd1;
          end
        end
        S_CORD: begin
          if (cz >= 0) begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - at;
          end else begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + at;
          end
          step <= step + 5'd1;
          if (step == 5'(CORDIC_STAGES - 1)) begin
            sub <= 2'd0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          case (sub)
            2'd0: scl <= mul_p;
            2'd1: cx <= ((scl <<< 16) + mul_p) >>> 24;
            2'd2: scl <= mul_p;
            default: begin
              cy <= ((scl <<< 16) + mul_p) >>> 24;
              state <= S_PR;
            end
          endcase
          sub <= sub + 2'd1;
        end
        S_PR: begin
          case (sub)
            2'd0: desu <= clamp64(mul_q, -64'(MAX_VELOCITY), 64'(MAX_VELOCITY));
            2'd1: out_data.pitch_cmd <= 32'(clamp64(mul_q, -64'(MAX_TILT), 64'(MAX_TILT)));
            2'd2: desv <= clamp64(mul_q, -64'(MAX_VELOCITY), 64'(MAX_VELOCITY));
            default: begin
              out_data.roll_cmd <= 32'(clamp64(mul_q, -64'(MAX_TILT), 64'(MAX_TILT)));
              state <= S_YAW;
            end
          endcase
          sub <= sub + 2'd1;
        end
        S_YAW: begin
          out_data.yaw_rate_cmd <=
            32'(clamp64(mul_q, -64'(MAX_YAW_RATE), 64'(MAX_YAW_RATE)));
          err <= 32'(sat32(64'(item.pos_z) - 64'(goal_z)));
          state <= S_INT;
        end
        S_INT: begin
          alt_integral <= clamp64(alt_integral + mul_q,
                                  -64'sd140737488355328, 64'sd140737488355327);
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            de <= (first_step || item.time_step == 31'd0) ? 64'sd0 : sat32(div_q);
            desth <= 64'(hover_throttle);
            state <= S_PTERM;
          end
        end
        S_PTERM: begin
          desth <= desth + mul_q;
          state <= S_ITERM;
        end
        S_ITERM: begin
          desth <= desth + mul_q;
          state <= S_DTERM;
        end
        S_DTERM: begin
          desth <= desth + mul_q;
          out_data.throttle_cmd <= 17'(clamp64(desth + mul_q, 64'sd0, 64'sd65536));
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DTERM) begin
        last_err <= err;
        first_step <= 1'b0;
      end
      if (state == S_OUT && out_valid && !out_stall) begin
        alt_integral <= clamp64(alt_integral - (desth - th) * 2,
                                -64'sd140737488355328, 64'sd140737488355327);
      end
    end
  end

  `ASSERT_IMPLIES(a_stall_busy, clk, rst, out_valid, in_stall)
  `ASSERT_NEXT(a_out_clears, clk, rst, out_valid && !out_stall, !out_valid)
  `ASSERT_IMPLIES(a_onehot, clk, rst, 1'b1, $onehot(state))
endmodule

// File: rtl/qwc_divider.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module qwc_divider import qwc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [30:0]        divisor,
  output logic               done,
  output logic signed [63:0] quotient
);
  logic [63:0] mag;
  logic [63:0] quo;
  logic [31:0] rem;
  logic [6:0] count;
  logic neg;
  logic busy;
  logic [32:0] trial;

  assign trial = {rem, mag[63]} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd0;
        neg <= dividend[63];
        mag <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        rem <= 32'd0;
        quo <= 64'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[30:0], mag[63]};
          quo <= {quo[62:0], 1'b0};
        end
        mag <= {mag[62:0], 1'b0};
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
endmodule
